// ===== src/plb_pkg.sv =====
// Shared types and constants for the provider load balancer.
// No dependencies.
package plb_pkg;

    localparam int CNT_W  = 32;
    localparam int TIME_W = 64;
    localparam int ROT_W  = 32;
    localparam int PROD_W = 96;

    localparam logic [TIME_W-1:0] FASTEST_LIMIT = 64'd1000000000;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [TIME_W-1:0] time_t;
    typedef logic [PROD_W-1:0] prod_t;

    typedef enum logic [1:0] {
        MODE_ROUND_ROBIN  = 2'd0,
        MODE_LEAST_LOADED = 2'd1,
        MODE_FASTEST      = 2'd2,
        MODE_FIXED_ZERO   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_DESC  = 2'd1,
        STATUS_BAD_PROV = 2'd2
    } status_t;

    localparam logic [1:0] REG_SELECT_MODE    = 2'd0;
    localparam logic [1:0] REG_PROVIDER_COUNT = 2'd1;
    localparam logic [1:0] REG_AVAILABLE_MASK = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_RSCAN,
        ST_LEAST,
        ST_FAST,
        ST_CHECK,
        ST_UPD,
        ST_DONE
    } state_t;

endpackage

// ===== src/plb_stat_file.sv =====
// Per-provider served count and busy time store, cleared at reset.
// One read port, one write port. Depends on plb_pkg.
module plb_stat_file #(
    parameter int NSLOT = 8,
    parameter int IDX_W = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [IDX_W-1:0]  rd_idx,
    output plb_pkg::cnt_t     rd_cnt,
    output plb_pkg::time_t    rd_time,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  plb_pkg::cnt_t     wr_cnt,
    input  plb_pkg::time_t    wr_time
);
    import plb_pkg::*;

    cnt_t  cnt_reg  [NSLOT];
    time_t time_reg [NSLOT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSLOT; i++) begin
                cnt_reg[i]  <= '0;
                time_reg[i] <= '0;
            end
        end else if (wr_en) begin
            cnt_reg[wr_idx]  <= wr_cnt;
            time_reg[wr_idx] <= wr_time;
        end
    end

    assign rd_cnt  = cnt_reg[rd_idx];
    assign rd_time = time_reg[rd_idx];

endmodule

// ===== src/plb_mul.sv =====
// Shared 32x32 multiplier with registered product.
// Depends on plb_pkg.
module plb_mul (
    input  logic                aclk,
    input  plb_pkg::cnt_t       mul_a,
    input  plb_pkg::cnt_t       mul_b,
    output logic [63:0]         prod
);
    import plb_pkg::*;

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= {32'd0, mul_a} * {32'd0, mul_b};
    end

    assign prod = prod_reg;

endmodule

// ===== src/provider_load_balancer_unit.sv =====
// Provider load balancer: round robin, least loaded, fastest or fixed provider zero.
// Round robin reduces the rotation count modulo the live count, then scans; least loaded
// scans every slot; fastest compares each candidate in phases on the shared 32x32
// multiplier; fixed mode and a missing descriptor skip the scan. NSLOT = min(MAX_PROVIDERS, 8).
// One item at a time; s_ready returns as the result loads. Synchronous aresetn clears
// config, state, m_valid, statistics and rotation counter. Depends on plb_pkg, stats, mul.
module provider_load_balancer_unit #(
    parameter int MAX_PROVIDERS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_has_extension,
    input  logic [31:0] s_reported_delay,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [2:0]  m_chosen_provider
);
    import plb_pkg::*;

    localparam int NSLOT = (MAX_PROVIDERS < 8) ? MAX_PROVIDERS : 8;
    localparam int IDX_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam logic [IDX_W-1:0] PTR_LAST = IDX_W'(NSLOT - 1);

    // configuration
    logic [1:0] mode_reg;
    logic [3:0] pcount_reg;
    logic [7:0] mask_reg;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= '0;
            pcount_reg <= '0;
            mask_reg   <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SELECT_MODE:    mode_reg   <= pwdata[1:0];
                REG_PROVIDER_COUNT: pcount_reg <= pwdata[3:0];
                REG_AVAILABLE_MASK: mask_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SELECT_MODE:    prdata = {30'd0, mode_reg};
            REG_PROVIDER_COUNT: prdata = {28'd0, pcount_reg};
            REG_AVAILABLE_MASK: prdata = {24'd0, mask_reg};
            default:            prdata = '0;
        endcase
    end

    // availability
    logic [NSLOT-1:0] up_vec;
    logic [3:0]       up_cnt;

    always_comb begin
        up_cnt = '0;
        for (int i = 0; i < NSLOT; i++) begin
            up_vec[i] = mask_reg[i] && (4'(i) < pcount_reg);
            up_cnt    = up_cnt + {3'd0, up_vec[i]};
        end
    end

    // state and datapath registers
    state_t           state_reg, state_next;
    logic [ROT_W-1:0] rot_reg, rot_next;
    logic [31:0]      delay_reg, delay_next;
    logic [ROT_W-1:0] rsh_reg, rsh_next;
    logic [2:0]       rem_reg, rem_next;
    logic [2:0]       nib_reg, nib_next;
    logic [2:0]       seen_reg, seen_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic             found_reg, found_next;
    cnt_t             low_reg, low_next;
    logic [2:0]       ph_reg, ph_next;
    time_t            bt_reg, bt_next;
    cnt_t             bc_reg, bc_next;
    prod_t            x_reg, x_next;
    prod_t            y_reg, y_next;
    logic [1:0]       stat_reg, stat_next;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic [2:0]       m_chosen_reg, m_chosen_next;

    logic        s_acc;
    cnt_t        rd_cnt;
    time_t       rd_time;
    logic        wr_en;
    cnt_t        mul_a, mul_b;
    logic [63:0] prod;
    logic [6:0]  mod_v;
    logic [6:0]  up7;
    logic        out_free;
    logic        is_cand;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_cand  = up_vec[ptr_reg] && (rd_cnt != '0);

    plb_stat_file #(
        .NSLOT (NSLOT),
        .IDX_W (IDX_W)
    ) u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_idx  (ptr_reg),
        .rd_cnt  (rd_cnt),
        .rd_time (rd_time),
        .wr_en   (wr_en),
        .wr_idx  (ptr_reg),
        .wr_cnt  (rd_cnt + 32'd1),
        .wr_time (rd_time + {32'd0, delay_reg})
    );

    plb_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    // remainder step: four bits of the rotation count per cycle
    always_comb begin
        up7   = {3'd0, up_cnt};
        mod_v = {rem_reg, rsh_reg[ROT_W-1 -: 4]};
        if (mod_v >= (up7 << 3)) mod_v = mod_v - (up7 << 3);
        if (mod_v >= (up7 << 2)) mod_v = mod_v - (up7 << 2);
        if (mod_v >= (up7 << 1)) mod_v = mod_v - (up7 << 1);
        if (mod_v >= up7)        mod_v = mod_v - up7;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (!s_has_extension) begin
                        state_next = ST_DONE;
                    end else begin
                        case (mode_reg)
                            MODE_ROUND_ROBIN:  state_next = (up_cnt == '0) ? ST_CHECK : ST_MOD;
                            MODE_LEAST_LOADED: state_next = ST_LEAST;
                            MODE_FASTEST:      state_next = ST_FAST;
                            default:           state_next = ST_CHECK;
                        endcase
                    end
                end
            end
            ST_MOD: begin
                if (nib_reg == 3'd7) state_next = ST_RSCAN;
            end
            ST_RSCAN: begin
                if ((up_vec[ptr_reg] && seen_reg == rem_reg) || ptr_reg == PTR_LAST)
                    state_next = ST_CHECK;
            end
            ST_LEAST: begin
                if (ptr_reg == PTR_LAST) state_next = ST_CHECK;
            end
            ST_FAST: begin
                if (ptr_reg == PTR_LAST && (!is_cand || ph_reg == 3'd5))
                    state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = up_vec[best_reg] ? ST_UPD : ST_DONE;
            end
            ST_UPD: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        rot_next      = rot_reg;
        delay_next    = delay_reg;
        rsh_next      = rsh_reg;
        rem_next      = rem_reg;
        nib_next      = nib_reg;
        seen_next     = seen_reg;
        ptr_next      = ptr_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        low_next      = low_reg;
        ph_next       = ph_reg;
        bt_next       = bt_reg;
        bc_next       = bc_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        stat_next     = stat_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_chosen_next = m_chosen_reg;
        wr_en         = 1'b0;
        mul_a         = rd_time[31:0];
        mul_b         = bc_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    delay_next = s_reported_delay;
                    ptr_next   = '0;
                    best_next  = '0;
                    found_next = 1'b0;
                    seen_next  = '0;
                    rem_next   = '0;
                    nib_next   = '0;
                    ph_next    = '0;
                    bt_next    = FASTEST_LIMIT;
                    bc_next    = 32'd1;
                    rsh_next   = rot_reg;
                    stat_next  = STATUS_NO_DESC;
                    if (s_has_extension && mode_reg == MODE_ROUND_ROBIN && up_cnt != '0)
                        rot_next = rot_reg + 32'd1;
                end
            end
            ST_MOD: begin
                rem_next = mod_v[2:0];
                rsh_next = rsh_reg << 4;
                nib_next = nib_reg + 3'd1;
            end
            ST_RSCAN: begin
                if (up_vec[ptr_reg]) begin
                    if (seen_reg == rem_reg) best_next = ptr_reg;
                    seen_next = seen_reg + 3'd1;
                end
                ptr_next = ptr_reg + 1'b1;
            end
            ST_LEAST: begin
                if (up_vec[ptr_reg] && (!found_reg || rd_cnt < low_reg)) begin
                    low_next   = rd_cnt;
                    best_next  = ptr_reg;
                    found_next = 1'b1;
                end
                ptr_next = ptr_reg + 1'b1;
            end
            ST_FAST: begin
                if (!is_cand) begin
                    ptr_next = ptr_reg + 1'b1;
                end else begin
                    ph_next = ph_reg + 3'd1;
                    case (ph_reg)
                        3'd0: begin
                            mul_a = rd_time[31:0];
                            mul_b = bc_reg;
                        end
                        3'd1: begin
                            mul_a  = rd_time[63:32];
                            mul_b  = bc_reg;
                            x_next = {32'd0, prod};
                        end
                        3'd2: begin
                            mul_a  = bt_reg[31:0];
                            mul_b  = rd_cnt;
                            x_next = x_reg + {prod, 32'd0};
                        end
                        3'd3: begin
                            mul_a  = bt_reg[63:32];
                            mul_b  = rd_cnt;
                            y_next = {32'd0, prod};
                        end
                        3'd4: begin
                            y_next = y_reg + {prod, 32'd0};
                        end
                        default: begin
                            if (x_reg < y_reg) begin
                                bt_next   = rd_time;
                                bc_next   = rd_cnt;
                                best_next = ptr_reg;
                            end
                            ph_next  = '0;
                            ptr_next = ptr_reg + 1'b1;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                ptr_next  = best_reg;
                stat_next = up_vec[best_reg] ? STATUS_OK : STATUS_BAD_PROV;
            end
            ST_UPD: begin
                wr_en = 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = stat_reg;
                    m_chosen_next = (stat_reg == STATUS_NO_DESC) ? 3'd0 : 3'(best_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rot_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rot_reg     <= rot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        delay_reg    <= delay_next;
        rsh_reg      <= rsh_next;
        rem_reg      <= rem_next;
        nib_reg      <= nib_next;
        seen_reg     <= seen_next;
        ptr_reg      <= ptr_next;
        best_reg     <= best_next;
        found_reg    <= found_next;
        low_reg      <= low_next;
        ph_reg       <= ph_next;
        bt_reg       <= bt_next;
        bc_reg       <= bc_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        stat_reg     <= stat_next;
        m_status_reg <= m_status_next;
        m_chosen_reg <= m_chosen_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_chosen_provider = m_chosen_reg;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for provider_load_balancer_unit: APB register setup,
// valid/ready request stimulus and an in-bench prediction of each routing result.
// Depends on plb_pkg and the RTL of the load balancer.
`timescale 1ns / 1ps

module testbench;
    import plb_pkg::*;

    localparam int NPROV = 8;

    typedef struct packed {
        status_t    status;
        logic [2:0] provider;
    } routing_t;

    class balance_scoreboard;
        mode_t       mode;
        logic [3:0]  prov_count;
        logic [7:0]  avail_mask;
        cnt_t        served[NPROV];
        time_t       busy[NPROV];
        logic [31:0] rotation;
        routing_t    expected_routing[$];
        int          failures;
        int          requests;
        int          status_hits[3];
        int          mode_hits[4];
        int          settings;

        function new();
            mode       = MODE_ROUND_ROBIN;
            prov_count = '0;
            avail_mask = '0;
            rotation   = '0;
            failures   = 0;
            requests   = 0;
            settings   = 0;
            for (int i = 0; i < NPROV; i++) begin
                served[i] = '0;
                busy[i]   = '0;
            end
            foreach (status_hits[i]) status_hits[i] = 0;
            foreach (mode_hits[i]) mode_hits[i] = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_SELECT_MODE:    mode = mode_t'(value[1:0]);
                REG_PROVIDER_COUNT: prov_count = value[3:0];
                REG_AVAILABLE_MASK: avail_mask = value[7:0];
                default: ;
            endcase
            settings++;
        endfunction

        function int unsigned live_count();
            return (prov_count > NPROV) ? NPROV : prov_count;
        endfunction

        function bit is_up(int unsigned i);
            return (i < 8) && avail_mask[i];
        endfunction

        function int unsigned pick_provider();
            int unsigned n;
            int unsigned up;
            int unsigned seen;
            int unsigned pos;
            int unsigned best;
            bit          found;
            cnt_t        low;
            time_t       best_time;
            cnt_t        best_cnt;
            prod_t       lhs;
            prod_t       rhs;
            n    = live_count();
            best = 0;
            case (mode)
                MODE_ROUND_ROBIN: begin
                    up = 0;
                    for (int unsigned i = 0; i < n; i++) if (is_up(i)) up++;
                    if (up != 0) begin
                        pos  = rotation % up;
                        rotation = rotation + 1;
                        seen = 0;
                        found = 0;
                        for (int unsigned i = 0; i < n; i++) begin
                            if (is_up(i) && !found) begin
                                if (seen == pos) begin
                                    best  = i;
                                    found = 1;
                                end
                                seen++;
                            end
                        end
                    end
                end
                MODE_LEAST_LOADED: begin
                    found = 0;
                    low   = '0;
                    for (int unsigned i = 0; i < n; i++) begin
                        if (is_up(i) && (!found || served[i] < low)) begin
                            low   = served[i];
                            best  = i;
                            found = 1;
                        end
                    end
                end
                MODE_FASTEST: begin
                    best_time = FASTEST_LIMIT;
                    best_cnt  = 1;
                    for (int unsigned i = 0; i < n; i++) begin
                        if (is_up(i) && served[i] != 0) begin
                            lhs = prod_t'(busy[i]) * prod_t'(best_cnt);
                            rhs = prod_t'(best_time) * prod_t'(served[i]);
                            if (lhs < rhs) begin
                                best_time = busy[i];
                                best_cnt  = served[i];
                                best      = i;
                            end
                        end
                    end
                end
                default: best = 0;
            endcase
            return best;
        endfunction

        function void note_request(logic ext, logic [31:0] delay);
            routing_t    r;
            int unsigned pick;
            requests++;
            if (!ext) begin
                r.status   = STATUS_NO_DESC;
                r.provider = '0;
            end else begin
                mode_hits[mode]++;
                pick       = pick_provider();
                r.provider = pick[2:0];
                if (pick >= live_count() || !is_up(pick)) begin
                    r.status = STATUS_BAD_PROV;
                end else begin
                    r.status     = STATUS_OK;
                    served[pick] = served[pick] + 1;
                    busy[pick]   = busy[pick] + time_t'(delay);
                end
            end
            status_hits[r.status]++;
            expected_routing.insert(expected_routing.size(), r);
        endfunction

        function void report(string msg);
            failures++;
            $error("%s", msg);
        endfunction

        function void check_routing(logic [1:0] status, logic [2:0] provider);
            routing_t r;
            if (expected_routing.size() == 0) begin
                report($sformatf("unexpected result: status %0d provider %0d",
                                 status, provider));
                return;
            end
            r = expected_routing.pop_front();
            if (status !== r.status)
                report($sformatf("status: expected %0d, got %0d", r.status, status));
            if (provider !== r.provider)
                report($sformatf("chosen_provider: expected %0d, got %0d",
                                 r.provider, provider));
        endfunction

        function int pending();
            return expected_routing.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_has_extension = 1'b0;
    logic [31:0] s_reported_delay = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [2:0]  m_chosen_provider;

    int unsigned s_idle_pct = 0;
    int unsigned m_idle_pct = 0;

    balance_scoreboard sb = new();

    provider_load_balancer_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_has_extension   (s_has_extension),
        .s_reported_delay  (s_reported_delay),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_chosen_provider (m_chosen_provider)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= m_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_routing(m_status, m_chosen_provider);
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // All driving tasks start and end just after a falling edge.
    task automatic apb_write(input logic [1:0] idx, input logic [7:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = ($urandom() << 8) | 32'(value);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, pwdata);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (sb.pending() > 0) @(negedge aclk);
    endtask

    task automatic configure(input mode_t mode, input logic [3:0] count,
                             input logic [7:0] mask);
        drain();
        apb_write(REG_SELECT_MODE, 8'(mode));
        apb_write(REG_PROVIDER_COUNT, 8'(count));
        apb_write(REG_AVAILABLE_MASK, mask);
    endtask

    task automatic send_request(input logic ext, input logic [31:0] delay);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_has_extension  = ext;
        s_reported_delay = delay;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(ext, delay);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_delay();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            3: return 32'd999_999_500 + $urandom_range(1000);
            default: return $urandom_range(2000);
        endcase
    endfunction

    initial begin
        int          nphase;
        int          nitems;
        mode_t       mode;
        logic [3:0]  count;
        logic [7:0]  mask;

        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed
        send_request(1'b1, 32'd5);
        send_request(1'b0, 32'hFFFF_FFFF);
        configure(MODE_ROUND_ROBIN, 4'd3, 8'h07);
        send_request(1'b1, 32'd0);
        send_request(1'b1, 32'hFFFF_FFFF);
        send_request(1'b1, 32'd17);
        send_request(1'b1, 32'd1);
        configure(MODE_ROUND_ROBIN, 4'd15, 8'hA5);
        send_request(1'b1, 32'd100);
        send_request(1'b1, 32'd200);
        send_request(1'b1, 32'd300);
        configure(MODE_LEAST_LOADED, 4'd8, 8'hFF);
        send_request(1'b1, 32'd10);
        send_request(1'b1, 32'd20);
        send_request(1'b0, 32'd30);
        configure(MODE_FASTEST, 4'd8, 8'h0F);
        send_request(1'b1, 32'd999_999_999);
        send_request(1'b1, 32'hFFFF_FFFF);
        drain();
        send_request(1'b1, 32'd50);
        send_request(1'b1, 32'd1_000_000_000);
        configure(MODE_FASTEST, 4'd2, 8'hFC);
        send_request(1'b1, 32'd7);
        configure(MODE_FIXED_ZERO, 4'd8, 8'hFE);
        send_request(1'b1, 32'd3);
        configure(MODE_FIXED_ZERO, 4'd0, 8'h01);
        send_request(1'b1, 32'd4);
        configure(MODE_LEAST_LOADED, 4'd4, 8'hF0);
        send_request(1'b1, 32'd9);

        // random phases, each with its own register setting
        nphase = 42;
        for (int p = 0; p < nphase; p++) begin
            mode = mode_t'($urandom_range(3));
            if ($urandom_range(9) == 0)
                count = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
            else
                count = 4'($urandom_range(1, 8));
            case ($urandom_range(9))
                0: mask = 8'h00;
                1: mask = 8'hFF;
                default: mask = 8'($urandom());
            endcase
            configure(mode, count, mask);
            if (p < nphase / 3) begin
                s_idle_pct = 9;
                m_idle_pct = 80;
            end else if (p < 2 * nphase / 3) begin
                s_idle_pct = 80;
                m_idle_pct = 9;
            end else begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            nitems = $urandom_range(28, 40);
            for (int k = 0; k < nitems; k++) begin
                if ($urandom_range(39) == 0) drain();
                send_request($urandom_range(99) < 92, pick_delay());
            end
        end

        drain();
        repeat (60) @(negedge aclk);
        if (sb.pending() > 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

        $display("%0d requests, %0d reg writes; ok %0d, no descriptor %0d, bad provider %0d",
                 sb.requests, sb.settings, sb.status_hits[STATUS_OK],
                 sb.status_hits[STATUS_NO_DESC], sb.status_hits[STATUS_BAD_PROV]);
        $display("Selections per mode: round robin %0d, least loaded %0d, fastest %0d, fixed %0d",
                 sb.mode_hits[MODE_ROUND_ROBIN], sb.mode_hits[MODE_LEAST_LOADED],
                 sb.mode_hits[MODE_FASTEST], sb.mode_hits[MODE_FIXED_ZERO]);
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
